@@ rtl/gb5_pkg.sv @@
// shared types, constants and sizes for the 5x5 gaussian blur stream unit
// no dependencies; imported by every rtl module of the block but gb5_ram
package gb5_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int LANES       = 4;
  localparam int SAMPLE_BITS = 8;

  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PIX_W      = LANES * SAMPLE_BITS;
  localparam int PORT_LANES = 4;
  localparam int LINE_STORES = 4;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CHAN_REG_W   = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int ROW_CNT_W    = 17;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST    = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST   = HEIGHT_REG_W'(480);
  localparam logic [CHAN_REG_W-1:0]   CHANNELS_RST = CHAN_REG_W'(3);

  localparam int WIN   = 5;
  localparam int SEL_W = 3;
  localparam logic [SEL_W-1:0] SEL_PIX = 3'd4;

  // kernel weights by ring position
  localparam int K_CORNER = 1;
  localparam int K_SIDE   = 4;
  localparam int K_RIM    = 7;
  localparam int K_INNER  = 16;
  localparam int K_CROSS  = 26;
  localparam int K_CENTER = 41;

  localparam int SUM_W       = 17;
  localparam int ROUND_BIAS  = 136;
  localparam int RECIP       = 122911;   // ceil(2^25 / 273)
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WOP_FILL,
    WOP_SHIFT,
    WOP_DUP
  } wop_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;              // [column][row]
  typedef logic [WIN-1:0][WIN-1:0][SAMPLE_BITS-1:0] lwin_t;       // [column][row]

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
    logic [CHAN_REG_W-1:0]   channels;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    wop_t             wop;
    logic             wr;
    logic             emit;
    logic             last;
    logic             eof;
  } op_t;

  typedef struct packed {
    op_t [2:0]                 ops;
    logic [1:0]                last_idx;
    logic [WIN-1:0][SEL_W-1:0] sel;
    logic [1:0]                wslot;
    pix_t                      pix;
  } plan_t;

  typedef struct packed {
    logic [COL_W-1:0]       addr;
    logic [LINE_STORES-1:0] we;
    pix_t                   wdata;
  } mem_req_t;

  typedef struct packed {
    logic                      valid;
    wop_t                      wop;
    logic                      emit;
    logic                      last;
    logic                      eof;
    logic [WIN-1:0][SEL_W-1:0] sel;
    pix_t                      pix;
  } wcmd_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic eof;
  } tag_t;

  typedef struct packed {
    logic [PORT_LANES-1:0][SAMPLE_BITS-1:0] blur;
    logic                                   last;
    logic                                   eof;
  } res_t;

endpackage

@@ rtl/gb5_ram.sv @@
// generic single-port ram, read-first, registered read data
// no dependencies
module gb5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/gb5_ctrl.sv @@
// config registers, frame position counters, item decode and column op issue
// depends on gb5_pkg
module gb5_ctrl import gb5_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  pix_t                  in_pix,
  input  logic                  credit_ok,
  output mem_req_t              mem_req,
  output logic                  issue_emit,
  output wcmd_t                 wcmd,
  output cfg_t                  cfg
);

  cfg_t                  cfg_r, cfg_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [COL_W-1:0]      drain_r, drain_nxt;
  logic [ROW_CNT_W-1:0]  row_r, row_nxt;
  logic                  p_valid_r, p_valid_nxt;
  plan_t                 plan_r, plan_nxt;
  logic [1:0]            idx_r, idx_nxt;
  wcmd_t                 wcmd_r, wcmd_nxt;

  logic [COL_W-1:0]      w_m1;
  logic [ROW_CNT_W-1:0]  h_eff, h_m1, row_up;
  logic [ROW_CNT_W-1:0]  rsum [WIN];
  logic [ROW_CNT_W-1:0]  drow [WIN];
  logic [WIN-1:0][SEL_W-1:0] psel, dsel;
  logic [COL_W:0]        xe;
  logic [COL_W-1:0]      dcol, c1, c2;
  logic                  pix_go, drn_go, row_ge2, col_end, drn_end, eof_hit;
  logic                  accept, load, cfg_hit;
  op_t                   op;
  logic                  issue_fire, last_op;

  // effective frame size
  always_comb begin
    if (cfg_r.width == '0) begin
      w_m1 = '0;
    end else if (32'(cfg_r.width) > 32'(MAX_WIDTH)) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(cfg_r.width - 1'b1);
    end
    h_eff = (cfg_r.height == '0) ? ROW_CNT_W'(1) : ROW_CNT_W'(cfg_r.height);
    h_m1  = h_eff - ROW_CNT_W'(1);
  end

  // line store slot per window row, pixel phase and drain phase
  always_comb begin
    for (int a = 0; a < WIN; a++) begin
      rsum[a] = row_r + ROW_CNT_W'(a);
      if (rsum[a] < ROW_CNT_W'(4)) begin
        drow[a] = '0;
      end else begin
        drow[a] = rsum[a] - ROW_CNT_W'(4);
      end
      if (drow[a] > h_m1) begin
        drow[a] = h_m1;
      end
      dsel[a] = SEL_W'(drow[a][1:0]);
      if (a == WIN - 1) begin
        psel[a] = SEL_PIX;
      end else if (rsum[a] >= ROW_CNT_W'(4)) begin
        psel[a] = SEL_W'(rsum[a][1:0]);
      end else begin
        psel[a] = '0;
      end
    end
  end

  // drain column clamps
  always_comb begin
    xe   = {1'b0, drain_r} + (COL_W+1)'(2);
    dcol = (xe > {1'b0, w_m1}) ? w_m1 : xe[COL_W-1:0];
    c1   = (w_m1 == '0) ? '0 : COL_W'(1);
    c2   = (w_m1 < COL_W'(2)) ? w_m1 : COL_W'(2);
  end

  assign op         = plan_r.ops[idx_r];
  assign issue_fire = p_valid_r && credit_ok;
  assign last_op    = (idx_r == plan_r.last_idx);
  assign in_ready   = !p_valid_r || (issue_fire && last_op);
  assign accept     = in_valid && in_ready;

  // item decode
  always_comb begin
    plan_nxt = '0;
    row_ge2  = (row_r >= ROW_CNT_W'(2));
    col_end  = (col_r >= w_m1);
    drn_end  = (drain_r >= w_m1);
    eof_hit  = (row_r == h_eff + ROW_CNT_W'(1)) && (drain_r == w_m1);
    pix_go   = !in_cmd && (row_r < h_eff);
    drn_go   = in_cmd && (row_r >= h_eff) && row_ge2;
    row_up   = row_r + ROW_CNT_W'(1);
    if (pix_go) begin
      plan_nxt.sel          = psel;
      plan_nxt.pix          = in_pix;
      plan_nxt.wslot        = row_r[1:0];
      plan_nxt.ops[0].col   = col_r;
      plan_nxt.ops[0].wr    = 1'b1;
      plan_nxt.ops[0].wop   = (col_r == '0) ? WOP_FILL : WOP_SHIFT;
      plan_nxt.ops[0].emit  = row_ge2 && (col_r >= COL_W'(2));
      if (row_ge2 && col_end) begin
        // right edge replication: two more shifts of the last column
        plan_nxt.ops[1].col  = col_r;
        plan_nxt.ops[1].wop  = WOP_DUP;
        plan_nxt.ops[1].emit = (col_r >= COL_W'(1));
        plan_nxt.ops[2].col  = col_r;
        plan_nxt.ops[2].wop  = WOP_DUP;
        plan_nxt.ops[2].emit = 1'b1;
        plan_nxt.ops[2].last = 1'b1;
        plan_nxt.last_idx    = 2'd2;
      end else begin
        plan_nxt.ops[0].last = plan_nxt.ops[0].emit;
        plan_nxt.last_idx    = 2'd0;
      end
    end else if (drn_go) begin
      plan_nxt.sel = dsel;
      if (drain_r == '0) begin
        plan_nxt.ops[0].col  = '0;
        plan_nxt.ops[0].wop  = WOP_FILL;
        plan_nxt.ops[1].col  = c1;
        plan_nxt.ops[1].wop  = WOP_SHIFT;
        plan_nxt.ops[2].col  = c2;
        plan_nxt.ops[2].wop  = WOP_SHIFT;
        plan_nxt.ops[2].emit = 1'b1;
        plan_nxt.ops[2].last = 1'b1;
        plan_nxt.ops[2].eof  = eof_hit;
        plan_nxt.last_idx    = 2'd2;
      end else begin
        plan_nxt.ops[0].col  = dcol;
        plan_nxt.ops[0].wop  = WOP_SHIFT;
        plan_nxt.ops[0].emit = 1'b1;
        plan_nxt.ops[0].last = 1'b1;
        plan_nxt.ops[0].eof  = eof_hit;
        plan_nxt.last_idx    = 2'd0;
      end
    end
  end

  assign load = accept && (pix_go || drn_go);

  // config writes and frame position
  always_comb begin
    cfg_nxt   = cfg_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          cfg_nxt.width = cfg_data[WIDTH_REG_W-1:0];
          cfg_hit       = 1'b1;
        end
        CFG_HEIGHT: begin
          cfg_nxt.height = cfg_data[HEIGHT_REG_W-1:0];
          cfg_hit        = 1'b1;
        end
        CFG_CHANNELS: begin
          cfg_nxt.channels = cfg_data[CHAN_REG_W-1:0];
          cfg_hit          = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = '0;
    end else if (accept && pix_go) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_up;
        if (row_up == h_eff && h_eff == ROW_CNT_W'(1)) begin
          row_nxt = ROW_CNT_W'(2);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else if (accept && drn_go) begin
      if (drn_end) begin
        drain_nxt = '0;
        row_nxt   = (row_up >= h_eff + ROW_CNT_W'(2)) ? '0 : row_up;
      end else begin
        drain_nxt = drain_r + COL_W'(1);
      end
    end
  end

  // pending item and op index
  always_comb begin
    p_valid_nxt = p_valid_r;
    idx_nxt     = idx_r;
    if (load) begin
      p_valid_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (issue_fire && last_op) begin
      p_valid_nxt = 1'b0;
    end else if (issue_fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    wcmd_nxt       = '0;
    wcmd_nxt.valid = issue_fire;
    wcmd_nxt.wop   = op.wop;
    wcmd_nxt.emit  = op.emit;
    wcmd_nxt.last  = op.last;
    wcmd_nxt.eof   = op.eof;
    wcmd_nxt.sel   = plan_r.sel;
    wcmd_nxt.pix   = plan_r.pix;
    mem_req.addr   = op.col;
    mem_req.wdata  = plan_r.pix;
    for (int s = 0; s < LINE_STORES; s++) begin
      mem_req.we[s] = issue_fire && op.wr && (plan_r.wslot == 2'(s));
    end
  end

  assign issue_emit = issue_fire && op.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= WIDTH_RST;
      cfg_r.height   <= HEIGHT_RST;
      cfg_r.channels <= CHANNELS_RST;
      col_r          <= '0;
      row_r          <= '0;
      drain_r        <= '0;
      p_valid_r      <= 1'b0;
      idx_r          <= '0;
      wcmd_r.valid   <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      drain_r      <= drain_nxt;
      p_valid_r    <= p_valid_nxt;
      idx_r        <= idx_nxt;
      wcmd_r.valid <= wcmd_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plan_r <= plan_nxt;
    end
    wcmd_r.wop  <= wcmd_nxt.wop;
    wcmd_r.emit <= wcmd_nxt.emit;
    wcmd_r.last <= wcmd_nxt.last;
    wcmd_r.eof  <= wcmd_nxt.eof;
    wcmd_r.sel  <= wcmd_nxt.sel;
    wcmd_r.pix  <= wcmd_nxt.pix;
  end

  assign wcmd = wcmd_r;
  assign cfg  = cfg_r;

endmodule

@@ rtl/gb5_window.sv @@
// 5x5 pixel window: builds a column from the line stores and shifts it in
// depends on gb5_pkg
module gb5_window import gb5_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wcmd_t                  wcmd,
  input  pix_t [LINE_STORES-1:0] store_q,
  output win_t                   win,
  output tag_t                   tag
);

  win_t                 win_r, win_nxt;
  tag_t                 tag_r, tag_nxt;
  logic [WIN-1:0][PIX_W-1:0] col_v;

  always_comb begin
    for (int a = 0; a < WIN; a++) begin
      if (wcmd.sel[a] == SEL_PIX) begin
        col_v[a] = wcmd.pix;
      end else begin
        col_v[a] = store_q[wcmd.sel[a][1:0]];
      end
    end
  end

  always_comb begin
    win_nxt = win_r;
    if (wcmd.valid) begin
      case (wcmd.wop)
        WOP_FILL: begin
          for (int b = 0; b < WIN; b++) begin
            win_nxt[b] = col_v;
          end
        end
        WOP_SHIFT: begin
          for (int b = 0; b < WIN - 1; b++) begin
            win_nxt[b] = win_r[b+1];
          end
          win_nxt[WIN-1] = col_v;
        end
        WOP_DUP: begin
          for (int b = 0; b < WIN - 1; b++) begin
            win_nxt[b] = win_r[b+1];
          end
          win_nxt[WIN-1] = win_r[WIN-1];
        end
        default: win_nxt = win_r;
      endcase
    end
    tag_nxt.valid = wcmd.valid && wcmd.emit;
    tag_nxt.last  = wcmd.last;
    tag_nxt.eof   = wcmd.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    tag_r.last <= tag_nxt.last;
    tag_r.eof  <= tag_nxt.eof;
  end

  assign win = win_r;
  assign tag = tag_r;

endmodule

@@ rtl/gb5_lane.sv @@
// one channel lane: ring sums, weighted sum with rounding bias, divide by 273
// depends on gb5_pkg
module gb5_lane import gb5_pkg::*; (
  input  logic                   clk,
  input  lwin_t                  lwin,
  output logic [SAMPLE_BITS-1:0] blur
);

  logic [9:0]             g1_r, g7_r, g16_r, g26_r;
  logic [10:0]            g4_r;
  logic [SAMPLE_BITS-1:0] g41_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-RECIP_SHIFT-1:0] quo;
  logic [SAMPLE_BITS-1:0] blur_r, blur_nxt;

  // stage a: pixels that share a weight
  always_ff @(posedge clk) begin
    g1_r  <= 10'(lwin[0][0]) + 10'(lwin[0][4]) + 10'(lwin[4][0]) + 10'(lwin[4][4]);
    g4_r  <= 11'(lwin[0][1]) + 11'(lwin[0][3]) + 11'(lwin[1][0]) + 11'(lwin[3][0])
           + 11'(lwin[4][1]) + 11'(lwin[4][3]) + 11'(lwin[1][4]) + 11'(lwin[3][4]);
    g7_r  <= 10'(lwin[0][2]) + 10'(lwin[2][0]) + 10'(lwin[4][2]) + 10'(lwin[2][4]);
    g16_r <= 10'(lwin[1][1]) + 10'(lwin[1][3]) + 10'(lwin[3][1]) + 10'(lwin[3][3]);
    g26_r <= 10'(lwin[1][2]) + 10'(lwin[2][1]) + 10'(lwin[3][2]) + 10'(lwin[2][3]);
    g41_r <= lwin[2][2];
  end

  // stage b: weighted sum plus half of 273
  always_comb begin
    sum_nxt = SUM_W'(32'(g1_r) * K_CORNER) + SUM_W'(32'(g4_r) * K_SIDE)
            + SUM_W'(32'(g7_r) * K_RIM) + SUM_W'(32'(g16_r) * K_INNER)
            + SUM_W'(32'(g26_r) * K_CROSS) + SUM_W'(32'(g41_r) * K_CENTER)
            + SUM_W'(ROUND_BIAS);
  end

  // stage c: reciprocal multiply, exact over the sum range
  always_comb begin
    prod = PROD_W'(sum_r) * PROD_W'(RECIP);
    quo  = prod[PROD_W-1:RECIP_SHIFT];
    if (quo > (PROD_W-RECIP_SHIFT)'(255)) begin
      blur_nxt = SAMPLE_BITS'(255);
    end else begin
      blur_nxt = quo[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    blur_r <= blur_nxt;
  end

  assign blur = blur_r;

endmodule

@@ rtl/gaussian_blur_5x5_stream_unit.sv @@
// 5x5 gaussian blur (weights sum 273) over a raster pixel stream, up to 4 lanes
// throughput: 1 item per cycle while the result queue has credit; a pixel
//   ending a row (row 2 on) and the first drain of each row issue three
//   column ops, the next item waiting for all of them; the window takes
//   one column per cycle while credit lasts
// reset: rst_n synchronous active low; clears counters, config to 1024x480x3;
//   line stores are not cleared and need no clearing pass
module gaussian_blur_5x5_stream_unit import gb5_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [SAMPLE_BITS-1:0] in_sample0,
  input  logic [SAMPLE_BITS-1:0] in_sample1,
  input  logic [SAMPLE_BITS-1:0] in_sample2,
  input  logic [SAMPLE_BITS-1:0] in_sample3,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_blur0,
  output logic [SAMPLE_BITS-1:0] out_blur1,
  output logic [SAMPLE_BITS-1:0] out_blur2,
  output logic [SAMPLE_BITS-1:0] out_blur3,
  output logic                   out_last_of_run,
  output logic                   out_end_of_frame
);

  logic [PORT_LANES-1:0][SAMPLE_BITS-1:0] samples;
  pix_t                   pix;
  mem_req_t               mem_req;
  wcmd_t                  wcmd;
  cfg_t                   cfg;
  logic                   issue_emit, credit_ok;
  pix_t [LINE_STORES-1:0] store_q;
  win_t                   win;
  tag_t                   win_tag;
  lwin_t [LANES-1:0]      lwin;
  logic [PORT_LANES-1:0][SAMPLE_BITS-1:0] lane_q;

  // lane pipeline tags, aligned with lane results after three stages
  tag_t                   tag_d1_r, tag_d2_r, tag_d3_r;

  // result queue and credits (an issued emitting op holds a credit until read out)
  res_t                   fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CREDIT_W-1:0]    count_r, count_nxt, credit_r, credit_nxt;
  logic                   push, pop;
  res_t                   res_in, res_out;
  logic [CHAN_REG_W-1:0]  lanes_on;
  logic [PORT_LANES-1:0]  lane_en;

  assign samples = {in_sample3, in_sample2, in_sample1, in_sample0};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pix[l*SAMPLE_BITS +: SAMPLE_BITS] = samples[l];
    end
  end

  // decode, counters, config and op issue
  gb5_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_pix     (pix),
    .credit_ok  (credit_ok),
    .mem_req    (mem_req),
    .issue_emit (issue_emit),
    .wcmd       (wcmd),
    .cfg        (cfg)
  );

  // four line stores, one per row slot (row mod 4), read-first
  for (genvar s = 0; s < LINE_STORES; s++) begin : g_store
    gb5_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_store (
      .clk   (clk),
      .we    (mem_req.we[s]),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (store_q[s])
    );
  end

  gb5_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wcmd    (wcmd),
    .store_q (store_q),
    .win     (win),
    .tag     (win_tag)
  );

  // split the window into per-channel byte windows
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int b = 0; b < WIN; b++) begin
        for (int a = 0; a < WIN; a++) begin
          lwin[l][b][a] = win[b][a][l*SAMPLE_BITS +: SAMPLE_BITS];
        end
      end
    end
  end

  // one filter lane per channel
  for (genvar l = 0; l < PORT_LANES; l++) begin : g_lane
    if (l < LANES) begin : g_on
      gb5_lane u_lane (
        .clk  (clk),
        .lwin (lwin[l]),
        .blur (lane_q[l])
      );
    end else begin : g_off
      assign lane_q[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_d1_r.valid <= 1'b0;
      tag_d2_r.valid <= 1'b0;
      tag_d3_r.valid <= 1'b0;
    end else begin
      tag_d1_r.valid <= win_tag.valid;
      tag_d2_r.valid <= tag_d1_r.valid;
      tag_d3_r.valid <= tag_d2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_d1_r.last <= win_tag.last;
    tag_d1_r.eof  <= win_tag.eof;
    tag_d2_r.last <= tag_d1_r.last;
    tag_d2_r.eof  <= tag_d1_r.eof;
    tag_d3_r.last <= tag_d2_r.last;
    tag_d3_r.eof  <= tag_d2_r.eof;
  end

  // merge: unused channels read as zero
  always_comb begin
    if (cfg.channels == '0) begin
      lanes_on = CHAN_REG_W'(1);
    end else if (32'(cfg.channels) > 32'(LANES)) begin
      lanes_on = CHAN_REG_W'(LANES);
    end else begin
      lanes_on = cfg.channels;
    end
    for (int l = 0; l < PORT_LANES; l++) begin
      lane_en[l]     = (32'(l) < 32'(lanes_on));
      res_in.blur[l] = lane_en[l] ? lane_q[l] : '0;
    end
    res_in.last = tag_d3_r.last;
    res_in.eof  = tag_d3_r.eof;
  end

  assign push      = tag_d3_r.valid;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign credit_ok = (credit_r < CREDIT_W'(FIFO_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + CREDIT_W'(push) - CREDIT_W'(pop);
    credit_nxt = credit_r + CREDIT_W'(issue_emit) - CREDIT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      credit_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res_in;
    end
  end

  assign res_out          = fifo_r[rd_ptr_r];
  assign out_blur0        = res_out.blur[0];
  assign out_blur1        = res_out.blur[1];
  assign out_blur2        = res_out.blur[2];
  assign out_blur3        = res_out.blur[3];
  assign out_last_of_run  = res_out.last;
  assign out_end_of_frame = res_out.eof;

endmodule

@@ sim/gaussian_blur_5x5_stream_unit_tb.sv @@
// self-checking testbench for gaussian_blur_5x5_stream_unit: directed table, then random frames
// depends on rtl/gb5_pkg.sv and rtl/gaussian_blur_5x5_stream_unit.sv
`timescale 1ns / 1ps

module gaussian_blur_5x5_stream_unit_tb;
  import gb5_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // index past the register list
  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_DRAIN = 1'b1;
  localparam int SETTLE = 20;  // cycles to let an item with no result fall through

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic [SAMPLE_BITS-1:0] in_sample0 = '0, in_sample1 = '0, in_sample2 = '0, in_sample3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_blur0, out_blur1, out_blur2, out_blur3;
  logic out_last_of_run, out_end_of_frame;

  always #6 clk = ~clk;

  gaussian_blur_5x5_stream_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_sample0(in_sample0), .in_sample1(in_sample1),
    .in_sample2(in_sample2), .in_sample3(in_sample3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_blur0(out_blur0), .out_blur1(out_blur1),
    .out_blur2(out_blur2), .out_blur3(out_blur3),
    .out_last_of_run(out_last_of_run), .out_end_of_frame(out_end_of_frame)
  );

  // ---------------------------------------------------------------------------
  // blur predictor: own copy of the line stores, window, frame position, regs
  // ---------------------------------------------------------------------------
  localparam int KERN [5][5] = '{
    '{1, 4, 7, 4, 1}, '{4, 16, 26, 16, 4}, '{7, 26, 41, 26, 7},
    '{4, 16, 26, 16, 4}, '{1, 4, 7, 4, 1}
  };

  logic [PIX_W-1:0] line_mem [LINE_STORES*MAX_WIDTH];
  logic [PIX_W-1:0] win [5][5];  // [column][row]
  int unsigned col_pos, row_pos, drain_pos;
  int unsigned width_reg, height_reg, chan_reg;
  res_t blurred_q [$];  // expected output pixels, oldest first
  int errors = 0;
  bit calm = 1'b0;      // no idling on either side while set

  function automatic int unsigned eff_width();
    return (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 1) ? 1 : height_reg;
  endfunction

  function automatic bit draining();
    return row_pos >= eff_height() && row_pos >= 2;
  endfunction

  function automatic logic [PIX_W-1:0] line_at(int unsigned row, int unsigned col);
    return line_mem[(row & 3) * MAX_WIDTH + (col % MAX_WIDTH)];
  endfunction

  function automatic res_t blur_window(bit eof);
    res_t r;
    int unsigned lanes, s, v;
    lanes = (chan_reg < 1) ? 1 : (chan_reg > LANES) ? LANES : chan_reg;
    for (int l = 0; l < 4; l++) begin
      s = 0;
      for (int a = 0; a < 5; a++)
        for (int b = 0; b < 5; b++)
          s += KERN[a][b] * win[b][a][8*l +: 8];
      v = (s + 136) / 273;
      if (v > 255) v = 255;
      r.blur[l] = (l < lanes) ? v[7:0] : 8'd0;
    end
    r.last = 1'b0;
    r.eof = eof;
    return r;
  endfunction

  task automatic window_shift(input logic [PIX_W-1:0] v [5]);
    for (int b = 0; b < 4; b++)
      for (int a = 0; a < 5; a++) win[b][a] = win[b+1][a];
    for (int a = 0; a < 5; a++) win[4][a] = v[a];
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_WIDTH:    width_reg = val & 'h7ff;
      CFG_HEIGHT:   height_reg = val & 'hffff;
      CFG_CHANNELS: chan_reg = val & 'h7;
      default: ;
    endcase
    if (idx != CFG_UNUSED) begin
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
    end
    @(negedge clk);
  endtask

  // advance the predictor by one transfer; queues the results it causes
  task automatic blur_step(input bit cmd, input logic [PIX_W-1:0] pix, output bit acted);
    int unsigned w, h, c, r, x, y, rr, col, row;
    logic [PIX_W-1:0] v [5];
    res_t run [$];
    w = eff_width();
    h = eff_height();
    acted = 1'b0;
    if (cmd == CMD_PIXEL) begin
      if (row_pos >= h) return;  // pixel during drain is dropped
      c = col_pos;
      r = row_pos;
      for (int i = 0; i < 4; i++) begin
        rr = (r + i >= 4) ? r + i - 4 : 0;
        v[i] = line_at(rr, c);
      end
      v[4] = pix;
      line_mem[(r & 3) * MAX_WIDTH + (c % MAX_WIDTH)] = pix;
      if (c == 0) begin
        for (int b = 0; b < 5; b++)
          for (int a = 0; a < 5; a++) win[b][a] = v[a];
      end else begin
        window_shift(v);
      end
      if (r >= 2) begin
        if (c >= 2) run.push_back(blur_window(1'b0));
        // row end: flush the right border columns by replication
        if (c == w - 1) begin
          window_shift(v);
          if (c >= 1) run.push_back(blur_window(1'b0));
          window_shift(v);
          run.push_back(blur_window(1'b0));
        end
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos == h && h == 1) row_pos = 2;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      if (!draining()) return;  // drain outside the drain phase is ignored
      y = row_pos - 2;
      x = drain_pos;
      for (int b = 0; b < 5; b++) begin
        col = (x + b >= 2) ? x + b - 2 : 0;
        if (col > w - 1) col = w - 1;
        for (int a = 0; a < 5; a++) begin
          row = (y + a >= 2) ? y + a - 2 : 0;
          if (row > h - 1) row = h - 1;
          win[b][a] = line_at(row, col);
        end
      end
      run.push_back(blur_window(y == h - 1 && x == w - 1));
      if (x + 1 >= w) begin
        drain_pos = 0;
        row_pos++;
        if (row_pos >= h + 2) row_pos = 0;
      end else begin
        drain_pos = x + 1;
      end
    end
    acted = 1'b1;
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) blurred_q.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // idling helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side: random stalls, sometimes none for a while
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // result checker, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.blur = {out_blur3, out_blur2, out_blur1, out_blur0};
      got.last = out_last_of_run;
      got.eof = out_end_of_frame;
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected transfer blur=%h last=%b eof=%b",
                 $time, got.blur, got.last, got.eof);
        errors++;
      end else begin
        want = blurred_q.pop_front();
        for (int l = 0; l < 4; l++)
          if (got.blur[l] !== want.blur[l]) begin
            $display("%0t: blur%0d expected %h got %h", $time, l, want.blur[l], got.blur[l]);
            errors++;
          end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last, got.last);
          errors++;
        end
        if (got.eof !== want.eof) begin
          $display("%0t: end_of_frame expected %b got %b", $time, want.eof, got.eof);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input driver: call at a falling edge; returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send(input bit cmd, input logic [PIX_W-1:0] pix,
                      input bit typed, input res_t typed_res, output bit acted);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    {in_sample3, in_sample2, in_sample1, in_sample0} <= pix;
    do @(posedge clk); while (!in_ready);
    blur_step(cmd, pix, acted);
    // rows with a value typed into the table replace the predicted one
    if (typed) begin
      void'(blurred_q.pop_back());
      blurred_q.push_back(typed_res);
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // let every expected transfer arrive, then the tail of any silent item
  task automatic drain_out();
    while (blurred_q.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned ch,
                           input bit junk);
    int first;
    first = $urandom_range(0, 2);
    if (junk) write_reg(CFG_UNUSED, $urandom);
    for (int k = 0; k < 3; k++)
      case ((first + k) % 3)
        0: write_reg(CFG_WIDTH, w);
        1: write_reg(CFG_HEIGHT, h);
        default: write_reg(CFG_CHANNELS, ch);
      endcase
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed table: 1x1 frame with four lanes, so a drain repeats its pixel
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit               cmd;
    logic [PIX_W-1:0] pix;
    bit               typed;
    logic [PIX_W-1:0] blur;
  } dir_row_t;

  localparam int DIR_N = 12;
  dir_row_t dir_tab [DIR_N] = '{
    '{CMD_DRAIN, 32'h0,        1'b0, 32'h0},         // drain before any pixel: ignored
    '{CMD_PIXEL, 32'hffffffff, 1'b0, 32'h0},         // brightest pixel
    '{CMD_PIXEL, 32'h00000000, 1'b0, 32'h0},         // pixel during drain: dropped
    '{CMD_DRAIN, 32'h0,        1'b1, 32'hffffffff},  // full scale stays full scale
    '{CMD_DRAIN, 32'h0,        1'b0, 32'h0},         // frame done: ignored
    '{CMD_PIXEL, 32'hff00ff00, 1'b0, 32'h0},
    '{CMD_DRAIN, 32'h0,        1'b1, 32'hff00ff00},
    '{CMD_PIXEL, 32'hfe7f8001, 1'b0, 32'h0},
    '{CMD_DRAIN, 32'h0,        1'b1, 32'hfe7f8001},
    '{CMD_PIXEL, 32'h00000000, 1'b0, 32'h0},         // darkest pixel
    '{CMD_DRAIN, 32'h0,        1'b1, 32'h00000000},
    '{CMD_PIXEL, 32'h12345678, 1'b0, 32'h0}          // left mid-frame for the reconfig
  };

  // random phases: small frames mostly, plus the register extremes
  typedef struct {
    int unsigned w, h, ch, items;
    bit junk;
  } phase_t;

  localparam int PH_N = 11;
  phase_t phases [PH_N] = '{
    '{5, 4, 3, 40, 1'b0},
    '{1, 1, 1, 20, 1'b1},    // single pixel frame, index past the list written too
    '{2, 2, 4, 20, 1'b0},
    '{3, 1, 2, 20, 1'b0},
    '{0, 0, 0, 15, 1'b0},    // zero registers act as 1x1, one lane
    '{7, 5, 5, 60, 1'b1},    // lane count above four
    '{4, 3, 7, 40, 1'b0},
    '{2047, 2, 4, 30, 1'b0},    // width above the line length, start of the top row
    '{16, 6, 4, 100, 1'b0},
    '{2, 65535, 3, 30, 1'b0},   // tallest frame, only its top rows
    '{6, 3, 1, 30, 1'b0}
  };

  initial begin
    res_t tr;
    bit acted, cmd;
    int unsigned done;
    logic [PIX_W-1:0] pix;

    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    chan_reg = CHANNELS_RST;
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    set_frame(1, 1, 4, 1'b0);
    calm = 1'b1;
    foreach (dir_tab[i]) begin
      tr.blur = dir_tab[i].blur;
      tr.last = 1'b1;
      tr.eof = 1'b1;
      if (i == 6) calm = 1'b0;
      send(dir_tab[i].cmd, dir_tab[i].pix, dir_tab[i].typed, tr, acted);
    end
    in_valid <= 1'b0;
    drain_out();

    // random part: mostly well-formed frames, some stray drains and pixels
    foreach (phases[p]) begin
      set_frame(phases[p].w, phases[p].h, phases[p].ch, phases[p].junk);
      calm = (p % 3 == 2);
      done = 0;
      while (done < phases[p].items) begin
        cmd = draining() ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
        for (int l = 0; l < 4; l++)
          pix[8*l +: 8] = ($urandom_range(0, 3) == 0) ?
                          ($urandom_range(0, 1) ? 8'hff : 8'h00) : 8'($urandom);
        send(cmd, pix, 1'b0, tr, acted);
        if (acted) done++;
      end
      in_valid <= 1'b0;
      drain_out();
    end

    if (errors == 0) begin
      $display("gaussian_blur_5x5_stream_unit_tb OK");
    end else begin
      $display("gaussian_blur_5x5_stream_unit_tb NOT OK");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #50ms;
    $display("gaussian_blur_5x5_stream_unit_tb NOT OK");
    $finish;
  end

endmodule
